// ===== sv/mtp_pkg.sv =====
package mtp_pkg;

  // Parser phase; the encoding doubles as the part code reported after an error
  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_SUB  = 3'd2,
    PH_SEMI = 3'd3,
    PH_NAME = 3'd4,
    PH_VAL  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    PART_TYPE    = 3'd0,
    PART_SLASH   = 3'd1,
    PART_SUBTYPE = 3'd2,
    PART_SEMI    = 3'd3,
    PART_NAME    = 3'd4,
    PART_EQUALS  = 3'd5,
    PART_VALUE   = 3'd6
  } part_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SLASH  = 3'd1,
    ST_TYPE_LONG = 3'd2,
    ST_SUB_LONG  = 3'd3,
    ST_NO_EQ     = 3'd4,
    ST_NAME_LONG = 3'd5,
    ST_EMPTY_VAL = 3'd6,
    ST_VAL_LONG  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_SLASH  = 3'd1,
    CLS_SEMI   = 3'd2,
    CLS_EQUALS = 3'd3,
    CLS_SPACE  = 3'd4
  } char_class_t;

  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [7:0] MAX_PART_LEN_RST = 8'hFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Classified character handed from front to back
  typedef struct packed {
    logic [7:0]  byte_lo;
    logic        last;
    char_class_t cls;
  } char_item_t;

endpackage

// ===== sv/mtp_if.sv =====
interface mtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface mtp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_keep;
  logic [2:0] part_code;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] type_length;
  logic [7:0] subtype_length;
  logic [7:0] name_length;
  logic [7:0] value_length;

  modport source (
    output valid, output out_byte, output out_keep, output part_code,
    output done_res, output status, output type_length, output subtype_length,
    output name_length, output value_length, input ready
  );
  modport sink (
    input valid, input out_byte, input out_keep, input part_code,
    input done_res, input status, input type_length, input subtype_length,
    input name_length, input value_length, output ready
  );
endinterface

// ===== sv/mtp_front.sv =====
module mtp_front (
  input  logic                clk,
  input  logic                rst,
  mtp_in_if.sink              byte_chan,
  output logic                cls_valid,
  output mtp_pkg::char_item_t cls_item,
  input  logic                cls_ready
);

  mtp_pkg::char_item_t item_next;
  logic                take;

  // Lowercase and classify the incoming character
  always_comb begin
    item_next.last = byte_chan.in_last;
    if (byte_chan.in_byte >= mtp_pkg::CHAR_UPPER_A &&
        byte_chan.in_byte <= mtp_pkg::CHAR_UPPER_Z) begin
      item_next.byte_lo = byte_chan.in_byte + mtp_pkg::CASE_OFFSET;
    end else begin
      item_next.byte_lo = byte_chan.in_byte;
    end
    priority if (byte_chan.in_byte == mtp_pkg::CHAR_SLASH) begin
      item_next.cls = mtp_pkg::CLS_SLASH;
    end else if (byte_chan.in_byte == mtp_pkg::CHAR_SEMI) begin
      item_next.cls = mtp_pkg::CLS_SEMI;
    end else if (byte_chan.in_byte == mtp_pkg::CHAR_EQUALS) begin
      item_next.cls = mtp_pkg::CLS_EQUALS;
    end else if (byte_chan.in_byte == mtp_pkg::CHAR_SPACE) begin
      item_next.cls = mtp_pkg::CLS_SPACE;
    end else begin
      item_next.cls = mtp_pkg::CLS_OTHER;
    end
  end

  // Accept whenever the stage is empty or drains this cycle
  assign byte_chan.ready = !cls_valid || cls_ready;
  assign take            = byte_chan.valid && byte_chan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (byte_chan.ready) begin
      cls_valid <= byte_chan.valid;
    end
  end

  // Hold payload until the next transfer
  always_ff @(posedge clk) begin
    if (take) begin
      cls_item <= item_next;
    end
  end

endmodule

// ===== sv/mtp_queue.sv =====
module mtp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  mtp_pkg::char_item_t push_item,
  output logic                pop_valid,
  input  logic                pop_ready,
  output mtp_pkg::char_item_t pop_item
);

  mtp_pkg::char_item_t                  entries [mtp_pkg::QUEUE_DEPTH];
  logic [mtp_pkg::QUEUE_PTR_W-1:0]      wr_ptr;
  logic [mtp_pkg::QUEUE_PTR_W-1:0]      rd_ptr;
  logic [mtp_pkg::QUEUE_CNT_W-1:0]      count;
  logic                                 push;
  logic                                 pop;

  function automatic logic [mtp_pkg::QUEUE_PTR_W-1:0] ptr_inc(
    input logic [mtp_pkg::QUEUE_PTR_W-1:0] ptr
  );
    if (ptr == mtp_pkg::QUEUE_PTR_W'(mtp_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return ptr + 1'b1;
    end
  endfunction

  assign push_ready = count != mtp_pkg::QUEUE_CNT_W'(mtp_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== sv/mtp_back.sv =====
module mtp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  mtp_pkg::char_item_t q_item,
  input  logic [7:0]          max_part_len,
  mtp_out_if.source           result_chan
);

  mtp_pkg::phase_t  phase;
  mtp_pkg::phase_t  phase_next;
  mtp_pkg::status_t error_code;
  mtp_pkg::status_t error_code_next;
  logic [7:0]       type_count;
  logic [7:0]       type_count_next;
  logic [7:0]       subtype_count;
  logic [7:0]       subtype_count_next;
  logic [7:0]       name_count;
  logic [7:0]       name_count_next;
  logic [7:0]       value_count;
  logic [7:0]       value_count_next;
  mtp_pkg::part_t   code;
  mtp_pkg::status_t status_fin;
  logic             keep;
  logic             pop;

  // Take a new character when the result register is free or drains
  assign q_ready = !result_chan.valid || result_chan.ready;
  assign pop     = q_valid && q_ready;

  // Phase transition and part counting for one character
  always_comb begin
    phase_next         = phase;
    error_code_next    = error_code;
    type_count_next    = type_count;
    subtype_count_next = subtype_count;
    name_count_next    = name_count;
    value_count_next   = value_count;
    code               = mtp_pkg::part_t'(phase);
    keep               = 1'b0;
    status_fin         = mtp_pkg::ST_OK;

    if (error_code == mtp_pkg::ST_OK) begin
      unique case (phase)
        mtp_pkg::PH_TYPE: begin
          if (q_item.cls == mtp_pkg::CLS_SLASH) begin
            code       = mtp_pkg::PART_SLASH;
            keep       = 1'b1;
            phase_next = mtp_pkg::PH_SUB;
          end else if (type_count >= max_part_len) begin
            error_code_next = mtp_pkg::ST_TYPE_LONG;
          end else begin
            type_count_next = type_count + 1'b1;
            keep            = 1'b1;
          end
        end
        mtp_pkg::PH_SUB: begin
          if (q_item.cls == mtp_pkg::CLS_SEMI) begin
            code       = mtp_pkg::PART_SEMI;
            keep       = 1'b1;
            phase_next = mtp_pkg::PH_SEMI;
          end else if (subtype_count >= max_part_len) begin
            error_code_next = mtp_pkg::ST_SUB_LONG;
          end else begin
            subtype_count_next = subtype_count + 1'b1;
            keep               = 1'b1;
          end
        end
        mtp_pkg::PH_SEMI, mtp_pkg::PH_NAME: begin
          if (phase == mtp_pkg::PH_SEMI && q_item.cls == mtp_pkg::CLS_SPACE) begin
            // drop the single space after the semicolon
            code       = mtp_pkg::PART_SEMI;
            phase_next = mtp_pkg::PH_NAME;
          end else if (q_item.cls == mtp_pkg::CLS_EQUALS) begin
            code       = mtp_pkg::PART_EQUALS;
            keep       = 1'b1;
            phase_next = mtp_pkg::PH_VAL;
          end else begin
            code       = mtp_pkg::PART_NAME;
            phase_next = mtp_pkg::PH_NAME;
            if (name_count >= max_part_len) begin
              error_code_next = mtp_pkg::ST_NAME_LONG;
            end else begin
              name_count_next = name_count + 1'b1;
              keep            = 1'b1;
            end
          end
        end
        default: begin
          code = mtp_pkg::PART_VALUE;
          if (value_count >= max_part_len) begin
            error_code_next = mtp_pkg::ST_VAL_LONG;
          end else begin
            value_count_next = value_count + 1'b1;
            keep             = 1'b1;
          end
        end
      endcase
    end

    // Final status on the last character; an earlier error wins
    status_fin = error_code_next;
    if (error_code_next == mtp_pkg::ST_OK) begin
      priority if (phase_next == mtp_pkg::PH_TYPE) begin
        status_fin = mtp_pkg::ST_NO_SLASH;
      end else if (phase_next == mtp_pkg::PH_SEMI || phase_next == mtp_pkg::PH_NAME) begin
        status_fin = mtp_pkg::ST_NO_EQ;
      end else if (phase_next == mtp_pkg::PH_VAL && value_count_next == '0) begin
        status_fin = mtp_pkg::ST_EMPTY_VAL;
      end else begin
        status_fin = mtp_pkg::ST_OK;
      end
    end
  end

  // Parser state; clear after the last character of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mtp_pkg::PH_TYPE;
      error_code    <= mtp_pkg::ST_OK;
      type_count    <= '0;
      subtype_count <= '0;
      name_count    <= '0;
      value_count   <= '0;
    end else if (pop) begin
      if (q_item.last) begin
        phase         <= mtp_pkg::PH_TYPE;
        error_code    <= mtp_pkg::ST_OK;
        type_count    <= '0;
        subtype_count <= '0;
        name_count    <= '0;
        value_count   <= '0;
      end else begin
        phase         <= phase_next;
        error_code    <= error_code_next;
        type_count    <= type_count_next;
        subtype_count <= subtype_count_next;
        name_count    <= name_count_next;
        value_count   <= value_count_next;
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_chan.valid <= 1'b0;
    end else if (q_ready) begin
      result_chan.valid <= q_valid;
    end
  end

  // Result payload; status and lengths only on the last character
  always_ff @(posedge clk) begin
    if (pop) begin
      result_chan.out_byte  <= q_item.byte_lo;
      result_chan.out_keep  <= keep;
      result_chan.part_code <= code;
      result_chan.done_res  <= q_item.last;
      if (q_item.last) begin
        result_chan.status         <= status_fin;
        result_chan.type_length    <= type_count_next;
        result_chan.subtype_length <= subtype_count_next;
        result_chan.name_length    <= name_count_next;
        result_chan.value_length   <= value_count_next;
      end else begin
        result_chan.status         <= mtp_pkg::ST_OK;
        result_chan.type_length    <= '0;
        result_chan.subtype_length <= '0;
        result_chan.name_length    <= '0;
        result_chan.value_length   <= '0;
      end
    end
  end

endmodule

// ===== sv/media_type_parser.sv =====
// Path: classify register, then the parse/result register behind a two-entry queue.
// Throughput: one character per cycle unless the result channel stalls; the parser's
//   phase and counters update with each character popped from the queue.
// Reset: synchronous, active high; clears parser state, queue and valid flags, and
//   sets max_part_len to 255. No clearing pass; input is taken the cycle after reset.
module media_type_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  mtp_in_if.sink     byte_chan,
  mtp_out_if.source  result_chan
);

  logic [7:0]          max_part_len_q;
  logic                cls_valid;
  logic                cls_ready;
  mtp_pkg::char_item_t cls_item;
  logic                q_valid;
  logic                q_ready;
  mtp_pkg::char_item_t q_item;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_part_len_q <= mtp_pkg::MAX_PART_LEN_RST;
    end else if (cfg_wr_en) begin
      max_part_len_q <= cfg_wr_data;
    end
  end

  mtp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_chan (byte_chan),
    .cls_valid (cls_valid),
    .cls_item  (cls_item),
    .cls_ready (cls_ready)
  );

  mtp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cls_valid),
    .push_ready (cls_ready),
    .push_item  (cls_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  mtp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .max_part_len (max_part_len_q),
    .result_chan  (result_chan)
  );

endmodule

// ===== sv/mtp_checker.sv =====
module mtp_checker (
  input logic       clk,
  input logic       rst,
  mtp_out_if.source result_chan
);

  // Stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    result_chan.valid && !result_chan.ready |=> result_chan.valid)
    else $error("result dropped while stalled");

  // Stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    result_chan.valid && !result_chan.ready |=>
      $stable(result_chan.out_byte) && $stable(result_chan.status) &&
      $stable(result_chan.done_res) && $stable(result_chan.type_length))
    else $error("result payload changed while stalled");

  // Status and lengths only on the last character
  assert property (@(posedge clk) disable iff (rst)
    result_chan.valid && !result_chan.done_res |->
      result_chan.status == mtp_pkg::ST_OK && result_chan.type_length == '0 &&
      result_chan.subtype_length == '0 && result_chan.name_length == '0 &&
      result_chan.value_length == '0)
    else $error("status or length on a non-final result");

  // Missing slash means no later part was counted
  assert property (@(posedge clk) disable iff (rst)
    result_chan.valid && result_chan.done_res &&
      result_chan.status == mtp_pkg::ST_NO_SLASH |->
      result_chan.subtype_length == '0 && result_chan.name_length == '0 &&
      result_chan.value_length == '0)
    else $error("later part counted without a slash");

  // Missing equals means no value was counted
  assert property (@(posedge clk) disable iff (rst)
    result_chan.valid && result_chan.done_res &&
      result_chan.status == mtp_pkg::ST_NO_EQ |-> result_chan.value_length == '0)
    else $error("value counted without an equals sign");

endmodule

bind media_type_parser mtp_checker u_mtp_checker (
  .clk         (clk),
  .rst         (rst),
  .result_chan (result_chan)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mtp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // One character as it goes onto the input channel
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } char_xfer_t;

  // Expected result for one character
  typedef struct packed {
    logic [7:0] chr;
    logic       keep;
    part_t      part;
    logic       done;
    status_t    status;
    logic [7:0] tlen;
    logic [7:0] slen;
    logic [7:0] nlen;
    logic [7:0] vlen;
  } parse_res_t;

  localparam int STALL_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte_r = 8'h00;
  logic       in_last_r = 1'b0;
  logic       res_ready = 1'b0;

  mtp_in_if  byte_chan ();
  mtp_out_if result_chan ();

  assign byte_chan.valid   = in_valid;
  assign byte_chan.in_byte = in_byte_r;
  assign byte_chan.in_last = in_last_r;
  assign result_chan.ready = res_ready;

  media_type_parser dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_chan   (byte_chan),
    .result_chan (result_chan)
  );

  // Parser state tracked alongside the block
  logic [7:0] part_limit = MAX_PART_LEN_RST;
  phase_t     ph = PH_TYPE;
  logic [7:0] type_cnt = 8'h00;
  logic [7:0] sub_cnt = 8'h00;
  logic [7:0] name_cnt = 8'h00;
  logic [7:0] value_cnt = 8'h00;
  status_t    parse_err = ST_OK;

  char_xfer_t char_backlog[$];
  parse_res_t expected_chars[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int strings_sent = 0;
  int chars_queued = 0;
  int chars_sent = 0;
  int results_seen = 0;
  int status_seen[8];
  int idle_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check room for one more character in a part; flag the long error if none
  function automatic logic fits(logic [7:0] cnt, status_t long_code);
    if (cnt >= part_limit) begin
      parse_err = long_code;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the parser by one character and return the result it yields
  function automatic parse_res_t normalize_char(logic [7:0] chr, logic last);
    parse_res_t r;
    r = '0;
    r.chr = (chr >= CHAR_UPPER_A && chr <= CHAR_UPPER_Z) ? chr + CASE_OFFSET : chr;
    r.part = part_t'(ph);
    r.done = last;
    if (parse_err == ST_OK) begin
      case (ph)
        PH_TYPE: begin
          if (chr == CHAR_SLASH) begin
            r.part = PART_SLASH;
            r.keep = 1'b1;
            ph = PH_SUB;
          end else begin
            r.keep = fits(type_cnt, ST_TYPE_LONG);
            if (r.keep) type_cnt++;
          end
        end
        PH_SUB: begin
          if (chr == CHAR_SEMI) begin
            r.part = PART_SEMI;
            r.keep = 1'b1;
            ph = PH_SEMI;
          end else begin
            r.keep = fits(sub_cnt, ST_SUB_LONG);
            if (r.keep) sub_cnt++;
          end
        end
        PH_SEMI, PH_NAME: begin
          if (ph == PH_SEMI && chr == CHAR_SPACE) begin
            // drop the one space right after the semicolon
            r.part = PART_SEMI;
            ph = PH_NAME;
          end else if (chr == CHAR_EQUALS) begin
            r.part = PART_EQUALS;
            r.keep = 1'b1;
            ph = PH_VAL;
          end else begin
            r.part = PART_NAME;
            ph = PH_NAME;
            r.keep = fits(name_cnt, ST_NAME_LONG);
            if (r.keep) name_cnt++;
          end
        end
        default: begin
          r.part = PART_VALUE;
          r.keep = fits(value_cnt, ST_VAL_LONG);
          if (r.keep) value_cnt++;
        end
      endcase
    end
    if (last) begin
      r.status = parse_err;
      if (parse_err == ST_OK) begin
        if (ph == PH_TYPE) r.status = ST_NO_SLASH;
        else if (ph == PH_SEMI || ph == PH_NAME) r.status = ST_NO_EQ;
        else if (ph == PH_VAL && value_cnt == 8'h00) r.status = ST_EMPTY_VAL;
      end
      r.tlen = type_cnt;
      r.slen = sub_cnt;
      r.nlen = name_cnt;
      r.vlen = value_cnt;
      // clear for the next string
      ph = PH_TYPE;
      type_cnt = 8'h00;
      sub_cnt = 8'h00;
      name_cnt = 8'h00;
      value_cnt = 8'h00;
      parse_err = ST_OK;
    end
    return r;
  endfunction

  function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", fname, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_string(byte_q_t s);
    char_xfer_t x;
    foreach (s[i]) begin
      x.chr = s[i];
      x.last = (i == s.size() - 1);
      char_backlog.push_back(x);
    end
    chars_queued += s.size();
    strings_sent++;
  endfunction

  // Mostly letters, the rest any byte; never the given delimiter
  function automatic logic [7:0] rand_char(int excl);
    logic [7:0] c;
    do begin
      case ($urandom_range(3))
        0: c = CHAR_UPPER_A + 8'($urandom_range(25));
        1: c = CHAR_UPPER_A + CASE_OFFSET + 8'($urandom_range(25));
        default: c = 8'($urandom_range(255));
      endcase
    end while (c == excl);
    return c;
  endfunction

  // Part lengths straddle small limits; stay short under large ones
  function automatic int rand_len();
    return $urandom_range((part_limit < 10) ? int'(part_limit) + 1 : 6);
  endfunction

  function automatic void queue_random_string();
    byte_q_t s;
    logic [7:0] d;
    int k;
    if ($urandom_range(9) < 2) begin
      // noise: short runs of delimiters and arbitrary bytes
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(5))
          0: d = CHAR_SLASH;
          1: d = CHAR_SEMI;
          2: d = CHAR_EQUALS;
          3: d = CHAR_SPACE;
          default: d = rand_char(-1);
        endcase
        s.push_back(d);
      end
    end else begin
      repeat (rand_len()) s.push_back(rand_char(CHAR_SLASH));
      s.push_back(CHAR_SLASH);
      repeat (rand_len()) s.push_back(rand_char(CHAR_SEMI));
      if ($urandom_range(3) != 0) begin
        s.push_back(CHAR_SEMI);
        if ($urandom_range(1) == 1) s.push_back(CHAR_SPACE);
        repeat (rand_len()) s.push_back(rand_char(CHAR_EQUALS));
        s.push_back(CHAR_EQUALS);
        repeat (rand_len()) s.push_back(rand_char(-1));
      end
      // cut some strings short
      if ($urandom_range(9) == 0 && s.size() > 1) begin
        k = $urandom_range(s.size() - 2);
        s = s[0:k];
      end
    end
    queue_string(s);
  endfunction

  // Wait until every transfer is done and every result is back
  task automatic settle();
    while (char_backlog.size() != 0 || in_valid || expected_chars.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(logic [7:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    part_limit = v;
  endtask

  // Drive the input channel; predict each transfer as it is accepted
  always @(posedge clk) begin : driver
    char_xfer_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && byte_chan.ready) begin
        expected_chars.push_back(normalize_char(in_byte_r, in_last_r));
        chars_sent++;
      end
      if (!in_valid || byte_chan.ready) begin
        if (char_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = char_backlog.pop_front();
          in_valid <= 1'b1;
          in_byte_r <= nxt.chr;
          in_last_r <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : monitor
    parse_res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (result_chan.valid && res_ready) begin
        if (expected_chars.size() == 0) begin
          $error("result with nothing expected: out_byte %0h", result_chan.out_byte);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          check_field("out_byte", want.chr, result_chan.out_byte);
          check_field("out_keep", want.keep, result_chan.out_keep);
          check_field("part_code", want.part, result_chan.part_code);
          check_field("done_res", want.done, result_chan.done_res);
          check_field("status", want.status, result_chan.status);
          check_field("type_length", want.tlen, result_chan.type_length);
          check_field("subtype_length", want.slen, result_chan.subtype_length);
          check_field("name_length", want.nlen, result_chan.name_length);
          check_field("value_length", want.vlen, result_chan.value_length);
          if (want.done) status_seen[want.status]++;
        end
        results_seen++;
      end
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run if no transfer happens for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && byte_chan.ready) || (result_chan.valid && res_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("media_type_parser: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int lims[7];
    int target;
    byte_q_t s;
    lims = '{0, 1, 3, 255, 0, 4, 255};
    lims[2] = $urandom_range(2, 9);
    lims[4] = $urandom_range(10, 254);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 10;
    stall_pct = 62;

    // directed strings under the reset limit
    s = '{8'h00, CHAR_SLASH, 8'hFF};
    queue_string(s);
    s = '{CHAR_UPPER_A, 8'h40, CHAR_SLASH, CHAR_UPPER_Z, 8'h5B, CHAR_SEMI, CHAR_SPACE,
          CHAR_SPACE, CHAR_SLASH, CHAR_EQUALS};
    queue_string(s);
    s = '{CHAR_SLASH, CHAR_SEMI, CHAR_EQUALS, CHAR_SEMI};
    queue_string(s);
    s = '{CHAR_UPPER_A + 8'd1};
    queue_string(s);
    s = '{CHAR_UPPER_A + CASE_OFFSET, CHAR_SLASH, CHAR_SEMI, 8'h78};
    queue_string(s);

    // random strings, one limit per phase
    for (int p = 0; p < 7; p++) begin
      settle();
      set_limit(lims[p]);
      if (p < 2) begin
        send_idle_pct = 10;
        stall_pct = 62;
      end else if (p < 5) begin
        send_idle_pct = 62;
        stall_pct = 10;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      if (p == 3) begin
        // saturate the type count at the full limit, then overflow it
        s = {};
        repeat (256) s.push_back(rand_char(CHAR_SLASH));
        s.push_back(CHAR_SLASH);
        s.push_back(CHAR_UPPER_A);
        queue_string(s);
      end
      target = chars_queued + 62;
      while (chars_queued < target) queue_random_string();
    end
    settle();
    repeat (8) @(negedge clk);

    $display("%0d strings, %0d characters sent, %0d results checked, limits 0 to 255",
             strings_sent, chars_sent, results_seen);
    $display("final status counts ok/slash/tlong/slong/eq/nlong/empty/vlong: %0s",
             $sformatf("%0d %0d %0d %0d %0d %0d %0d %0d",
                       status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                       status_seen[4], status_seen[5], status_seen[6], status_seen[7]));
    if (mismatches == 0) begin
      $display("media_type_parser: match");
    end else begin
      $display("media_type_parser: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mtp_pkg.sv
sv/mtp_if.sv
sv/mtp_front.sv
sv/mtp_queue.sv
sv/mtp_back.sv
sv/media_type_parser.sv
sv/mtp_checker.sv
dv/tb_top.sv
